>>> hw/rtl/hfd_pkg.sv
// Shared types and constants for the Hermite fractional delay line.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none

package hfd_pkg;

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int DELAY_W   = 26;
  localparam int FRAC_W    = 16;

  // Internal arithmetic widths
  localparam int DIFF_W    = SAMPLE_W + 1;   // difference of two samples
  localparam int ACC_W     = 31;             // Horner accumulator / coefficients
  localparam int PROD_W    = ACC_W + FRAC_W + 1;
  localparam int SUM_W     = PROD_W + 1;

  localparam int SAMPLE_MAX = 8388607;
  localparam int SAMPLE_MIN = -8388608;

  localparam int BUFFER_LENGTH_DEF = 1024;

  // Opcode values
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_FETCH,
    ST_DIFF,
    ST_A2,
    ST_B2,
    ST_MUL1,
    ST_ADD1,
    ST_MUL2,
    ST_ADD2,
    ST_MUL3,
    ST_ADD3
  } state_t;

  // Shared multiply-add unit operations
  typedef enum logic [1:0] {
    MAC_NOP,
    MAC_LOAD,
    MAC_MUL,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t                  op;
    logic signed [ACC_W-1:0]  addend;   // added at weight 2^16
    logic                     last;     // final step: round by 2^17, keep accumulator
  } mac_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/hfd_if.sv
// Valid/ready channel interfaces for the delay line input and result beats.
// Depends on hfd_pkg for field widths.
`default_nettype none

interface hfd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [hfd_pkg::SAMPLE_W-1:0]  sample_in;
  logic        [hfd_pkg::DELAY_W-1:0]   delay_q16;

  modport source (output valid, output opcode, output sample_in, output delay_q16,
                  input ready);
  modport sink   (input valid, input opcode, input sample_in, input delay_q16,
                  output ready);
endinterface

interface hfd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [hfd_pkg::SAMPLE_W-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hermite_fractional_delay_line.sv
// Circular delay line with 4-point cubic Hermite (Catmull-Rom) read interpolation.
// Depends on hfd_pkg, hfd_if, hfd_ram and hfd_mac.
//
// A write beat (opcode 0) advances the write position and stores sample_in; it gives
// no result. A read beat (opcode 1) clamps delay_q16 (Q10.16) to
// 1.0 .. BUFFER_LENGTH-3, fetches the four neighboring samples and returns the
// interpolated sample, saturated to 24 bits, on the output channel. After its accept
// edge a read holds ready low through the address step, the four reads through the
// single ring RAM port, the coefficient steps and three multiply/add passes through
// the one shared multiplier. The result is registered by the last pass, and the next
// beat can be taken in the cycle in which it is first valid. After reset the ring is
// zeroed by a clearing pass over all BUFFER_LENGTH addresses, during which no beat is
// taken. A finished result waits in an output register, and writes go on meanwhile.
// A further read holds in its last step until that register frees.
`default_nettype none

module hermite_fractional_delay_line #(
  parameter int BUFFER_LENGTH = hfd_pkg::BUFFER_LENGTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  hfd_in_if.sink     in,
  hfd_out_if.source  out
);

  localparam int AW = $clog2(BUFFER_LENGTH);
  localparam int CW = (AW + hfd_pkg::FRAC_W > hfd_pkg::DELAY_W) ?
                      AW + hfd_pkg::FRAC_W : hfd_pkg::DELAY_W;
  localparam int IW = CW - hfd_pkg::FRAC_W;   // integer delay width
  localparam int PW = IW + 2;                 // ring position arithmetic width
  localparam int SW = hfd_pkg::SAMPLE_W;
  localparam int DW = hfd_pkg::DIFF_W;
  localparam int AC = hfd_pkg::ACC_W;

  localparam logic [CW-1:0] LO_DELAY  = CW'(1) << hfd_pkg::FRAC_W;
  localparam logic [CW-1:0] HI_DELAY  = CW'(BUFFER_LENGTH - 3) << hfd_pkg::FRAC_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_LENGTH - 1);
  localparam logic [PW-1:0] RING_LEN  = PW'(BUFFER_LENGTH);
  localparam logic [2:0]    FETCH_END = 3'd4;

  hfd_pkg::state_t state, state_next;

  logic [AW-1:0]             wp;
  logic [AW-1:0]             wp_next;
  logic [AW-1:0]             clr_cnt;
  logic [AW-1:0]             rd_addr;
  logic [2:0]                k;
  logic [IW-1:0]             d;
  logic [hfd_pkg::FRAC_W-1:0] f;
  logic signed [SW-1:0]      qa, qb, qc, qd;
  logic signed [DW-1:0]      s0, v, dmb;
  logic signed [AC-1:0]      a2, nb2;
  logic                      out_valid;
  logic signed [SW-1:0]      sample_out;

  logic                      accept;
  logic                      out_free;
  logic [CW-1:0]             delay_ext;
  logic [CW-1:0]             delay_clamped;
  logic [PW-1:0]             pos;

  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [SW-1:0]             ram_wdata;
  logic [SW-1:0]             ram_rdata;

  hfd_pkg::mac_ctrl_t        mac_ctrl;
  logic signed [SW-1:0]      mac_sat;

  assign in.ready       = (state == hfd_pkg::ST_IDLE);
  assign accept         = in.valid && in.ready;
  assign out_free       = !out_valid || out.ready;
  assign out.valid      = out_valid;
  assign out.sample_out = sample_out;

  assign wp_next = (wp == LAST_ADDR) ? '0 : wp + AW'(1);

  // Delay clamp to 1.0 .. BUFFER_LENGTH-3
  assign delay_ext     = CW'(in.delay_q16);
  assign delay_clamped = (delay_ext < LO_DELAY) ? LO_DELAY :
                         (delay_ext > HI_DELAY) ? HI_DELAY : delay_ext;

  // Position of the newest neighbor: wp + 1 - d, modulo ring length
  assign pos = PW'(wp) + RING_LEN + PW'(1) - PW'(d);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hfd_pkg::ST_CLEAR: if (clr_cnt == LAST_ADDR) state_next = hfd_pkg::ST_IDLE;
      hfd_pkg::ST_IDLE: begin
        if (accept && in.opcode == hfd_pkg::OP_READ) state_next = hfd_pkg::ST_ADDR;
      end
      hfd_pkg::ST_ADDR:  state_next = hfd_pkg::ST_FETCH;
      hfd_pkg::ST_FETCH: if (k == FETCH_END) state_next = hfd_pkg::ST_DIFF;
      hfd_pkg::ST_DIFF:  state_next = hfd_pkg::ST_A2;
      hfd_pkg::ST_A2:    state_next = hfd_pkg::ST_B2;
      hfd_pkg::ST_B2:    state_next = hfd_pkg::ST_MUL1;
      hfd_pkg::ST_MUL1:  state_next = hfd_pkg::ST_ADD1;
      hfd_pkg::ST_ADD1:  state_next = hfd_pkg::ST_MUL2;
      hfd_pkg::ST_MUL2:  state_next = hfd_pkg::ST_ADD2;
      hfd_pkg::ST_ADD2:  state_next = hfd_pkg::ST_MUL3;
      hfd_pkg::ST_MUL3:  state_next = hfd_pkg::ST_ADD3;
      hfd_pkg::ST_ADD3:  if (out_free) state_next = hfd_pkg::ST_IDLE;
      default:           state_next = hfd_pkg::ST_CLEAR;
    endcase
  end

  // RAM port and shared unit control
  always_comb begin
    ram_we          = 1'b0;
    ram_addr        = rd_addr;
    ram_wdata       = '0;
    mac_ctrl.op     = hfd_pkg::MAC_NOP;
    mac_ctrl.addend = '0;
    mac_ctrl.last   = 1'b0;
    case (state)
      hfd_pkg::ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      hfd_pkg::ST_IDLE: begin
        if (accept && in.opcode == hfd_pkg::OP_WRITE) begin
          ram_we    = 1'b1;
          ram_addr  = wp_next;
          ram_wdata = in.sample_in;
        end
      end
      hfd_pkg::ST_B2: mac_ctrl.op = hfd_pkg::MAC_LOAD;
      hfd_pkg::ST_MUL1, hfd_pkg::ST_MUL2, hfd_pkg::ST_MUL3: begin
        mac_ctrl.op = hfd_pkg::MAC_MUL;
      end
      hfd_pkg::ST_ADD1: begin
        mac_ctrl.op     = hfd_pkg::MAC_ADD;
        mac_ctrl.addend = nb2;
      end
      hfd_pkg::ST_ADD2: begin
        mac_ctrl.op     = hfd_pkg::MAC_ADD;
        mac_ctrl.addend = AC'(s0);
      end
      hfd_pkg::ST_ADD3: begin
        mac_ctrl.op     = hfd_pkg::MAC_ADD;
        mac_ctrl.addend = AC'(qb) <<< 1;
        mac_ctrl.last   = 1'b1;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hfd_pkg::ST_CLEAR;
      wp        <= LAST_ADDR;
      clr_cnt   <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hfd_pkg::ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (accept && in.opcode == hfd_pkg::OP_WRITE) wp <= wp_next;
      if (state == hfd_pkg::ST_ADDR) begin
        k <= '0;
      end else if (state == hfd_pkg::ST_FETCH) begin
        k <= k + 3'd1;
      end
      if (state == hfd_pkg::ST_ADD3 && out_free) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      hfd_pkg::ST_IDLE: begin
        if (accept) begin
          d <= delay_clamped[CW-1:hfd_pkg::FRAC_W];
          f <= delay_clamped[hfd_pkg::FRAC_W-1:0];
        end
      end
      hfd_pkg::ST_ADDR: begin
        rd_addr <= (pos >= RING_LEN) ? AW'(pos - RING_LEN) : AW'(pos);
      end
      hfd_pkg::ST_FETCH: begin
        // issue reads newest-first, capture each from the registered RAM output on the next cycle
        if (!k[2]) rd_addr <= (rd_addr == '0) ? LAST_ADDR : rd_addr - AW'(1);
        case (k)
          3'd1:    qa <= ram_rdata;
          3'd2:    qb <= ram_rdata;
          3'd3:    qc <= ram_rdata;
          3'd4:    qd <= ram_rdata;
          default: ;
        endcase
      end
      hfd_pkg::ST_DIFF: begin
        s0  <= DW'(qc) - DW'(qa);
        v   <= DW'(qb) - DW'(qc);
        dmb <= DW'(qd) - DW'(qb);
      end
      hfd_pkg::ST_A2: a2  <= AC'(s0) + (AC'(v) <<< 2) + AC'(dmb);
      hfd_pkg::ST_B2: nb2 <= -(AC'(s0) + (AC'(v) <<< 1) + a2);
      hfd_pkg::ST_ADD3: if (out_free) sample_out <= mac_sat;
      default: ;
    endcase
  end

  hfd_ram #(
    .WIDTH (SW),
    .DEPTH (BUFFER_LENGTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  hfd_mac u_mac (
    .clk      (clk),
    .ctrl     (mac_ctrl),
    .load_val (a2),
    .frac     (f),
    .sat      (mac_sat)
  );

  // A result only appears out of the final Horner step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == hfd_pkg::ST_ADD3)
    else $error("result raised outside final step");

  // Ring is written only by the clearing pass or an accepted write beat
  a_ram_write: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == hfd_pkg::ST_CLEAR) ||
               (accept && in.opcode == hfd_pkg::OP_WRITE))
    else $error("unexpected ring write");

  // No beat is taken during the clearing pass
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (state == hfd_pkg::ST_CLEAR) |-> !in.ready)
    else $error("input ready during clearing pass");

  // Positions stay inside the ring
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (PW'(wp) < RING_LEN) && (PW'(rd_addr) < RING_LEN || state != hfd_pkg::ST_FETCH))
    else $error("ring position out of range");

  // A read fetch always ends four reads after its address was formed
  a_fetch_len: assert property (@(posedge clk) disable iff (rst)
    (state == hfd_pkg::ST_ADDR) |-> ##6 (state == hfd_pkg::ST_DIFF))
    else $error("fetch sequence length wrong");

endmodule

`default_nettype wire

>>> hw/rtl/hfd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module hfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/hfd_mac.sv
// Shared multiply / add / round unit for the Horner evaluation.
// Depends on hfd_pkg (widths, mac_ctrl_t).
`default_nettype none

module hfd_mac (
  input  wire logic                                 clk,
  input  wire hfd_pkg::mac_ctrl_t                   ctrl,
  input  wire logic signed [hfd_pkg::ACC_W-1:0]     load_val,
  input  wire logic        [hfd_pkg::FRAC_W-1:0]    frac,
  output logic signed      [hfd_pkg::SAMPLE_W-1:0]  sat
);

  localparam int SUM_W = hfd_pkg::SUM_W;
  localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(hfd_pkg::SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(hfd_pkg::SAMPLE_MIN);
  localparam logic signed [SUM_W-1:0] BIAS_16  = SUM_W'(1) <<< (hfd_pkg::FRAC_W - 1);
  localparam logic signed [SUM_W-1:0] BIAS_17  = SUM_W'(1) <<< hfd_pkg::FRAC_W;

  logic signed [hfd_pkg::ACC_W-1:0]   acc;
  logic signed [hfd_pkg::PROD_W-1:0]  prod;
  logic signed [hfd_pkg::FRAC_W:0]    frac_s;
  logic signed [SUM_W-1:0]            sum;
  logic signed [SUM_W-1:0]            biased;
  logic signed [SUM_W-1:0]            rnd;

  assign frac_s = $signed({1'b0, frac});

  // prod + addend*2^16, rounded half up by 2^16 (or 2^17 on the last step)
  assign sum    = SUM_W'(prod) + (SUM_W'(ctrl.addend) <<< hfd_pkg::FRAC_W);
  assign biased = sum + (ctrl.last ? BIAS_17 : BIAS_16);
  assign rnd    = ctrl.last ? (biased >>> (hfd_pkg::FRAC_W + 1))
                            : (biased >>> hfd_pkg::FRAC_W);

  // Saturate to the sample range
  always_comb begin
    if (rnd > SAT_HI) begin
      sat = hfd_pkg::SAMPLE_W'(hfd_pkg::SAMPLE_MAX);
    end else if (rnd < SAT_LO) begin
      sat = hfd_pkg::SAMPLE_W'(hfd_pkg::SAMPLE_MIN);
    end else begin
      sat = rnd[hfd_pkg::SAMPLE_W-1:0];
    end
  end

  // Accumulator and registered product
  always_ff @(posedge clk) begin
    case (ctrl.op)
      hfd_pkg::MAC_LOAD: acc  <= load_val;
      hfd_pkg::MAC_MUL:  prod <= acc * frac_s;
      hfd_pkg::MAC_ADD: begin
        if (!ctrl.last) begin
          acc <= rnd[hfd_pkg::ACC_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
